// File: hdl/b2b_pkg.sv
// Package: BLAKE2b constants, message schedule and shared types.
`default_nettype none
package b2b_pkg;

  localparam int WordW   = 64;
  localparam int NumRegs = 2;
  localparam int AddrW   = 3;
  localparam int DefaultRounds = 6;

  localparam logic [AddrW-1:0] RegDigestBytes = 3'd0;
  localparam logic [AddrW-1:0] RegKeyBytes    = 3'd4;

  localparam logic [63:0] Iv [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [3:0] Sigma [10][16] = '{
    '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15},
    '{4'd14,4'd10,4'd4,4'd8,4'd9,4'd15,4'd13,4'd6,4'd1,4'd12,4'd0,4'd2,4'd11,4'd7,4'd5,4'd3},
    '{4'd11,4'd8,4'd12,4'd0,4'd5,4'd2,4'd15,4'd13,4'd10,4'd14,4'd3,4'd6,4'd7,4'd1,4'd9,4'd4},
    '{4'd7,4'd9,4'd3,4'd1,4'd13,4'd12,4'd11,4'd14,4'd2,4'd6,4'd5,4'd10,4'd4,4'd0,4'd15,4'd8},
    '{4'd9,4'd0,4'd5,4'd7,4'd2,4'd4,4'd10,4'd15,4'd14,4'd1,4'd11,4'd12,4'd6,4'd8,4'd3,4'd13},
    '{4'd2,4'd12,4'd6,4'd10,4'd0,4'd11,4'd8,4'd3,4'd4,4'd13,4'd7,4'd5,4'd15,4'd14,4'd1,4'd9},
    '{4'd12,4'd5,4'd1,4'd15,4'd14,4'd13,4'd4,4'd10,4'd0,4'd7,4'd6,4'd3,4'd9,4'd2,4'd8,4'd11},
    '{4'd13,4'd11,4'd7,4'd14,4'd12,4'd1,4'd3,4'd9,4'd5,4'd0,4'd15,4'd4,4'd8,4'd6,4'd2,4'd10},
    '{4'd6,4'd15,4'd14,4'd9,4'd11,4'd3,4'd0,4'd8,4'd12,4'd2,4'd13,4'd7,4'd1,4'd4,4'd10,4'd5},
    '{4'd10,4'd2,4'd8,4'd4,4'd7,4'd6,4'd1,4'd5,4'd15,4'd11,4'd9,4'd14,4'd3,4'd12,4'd13,4'd0}
  };

  // Controller -> datapath commands
  typedef struct packed {
    logic       absorb;     // store accepted word, bump counter
    logic       comp_start; // load working vector
    logic       comp_final;
    logic       round_step; // one half round
    logic       comp_done;  // fold into chain value
    logic       pad_clear;  // zero the slot at the fill point
    logic       restart;    // reload chain value from parameters
    logic       out_load;   // load digest word
    logic [2:0] out_idx;
  } b2b_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [4:0] word_pos;
    logic       pending;
    logic       run_empty;
    logic [6:0] digest_len;
  } b2b_stat_t;

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    ror64 = (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

// File: hdl/b2b_if.sv
// Interfaces: valid/ready stream channels for words in and digest words out.
`default_nettype none
interface b2b_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  byte_count;
  logic        last_word;
  modport source (output valid, message_word, byte_count, last_word, input ready);
  modport sink   (input valid, message_word, byte_count, last_word, output ready);
endinterface

interface b2b_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        final_digest;
  modport source (output valid, digest_word, final_digest, input ready);
  modport sink   (input valid, digest_word, final_digest, output ready);
endinterface
`default_nettype wire

// File: hdl/b2b_datapath.sv
// Datapath: block buffer, counters, chain value, half-round mixing unit.
`default_nettype none
module b2b_datapath #(
  parameter int Rounds = b2b_pkg::DefaultRounds
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire b2b_pkg::b2b_cmd_t cmd,
  input  wire logic [63:0]      in_word,
  input  wire logic [3:0]       in_count,
  input  wire logic             cfg_we,
  input  wire logic             cfg_sel,
  input  wire logic [6:0]       cfg_data,
  output b2b_pkg::b2b_stat_t    stat,
  output logic [6:0]            reg_digest,
  output logic [6:0]            reg_key,
  output logic [63:0]           out_word
);
  localparam int RoundW = (Rounds > 1) ? $clog2(Rounds) : 1;

  logic [63:0] chain [8];
  logic [63:0] blk [16];
  logic [63:0] v [16];
  logic [4:0]  word_pos;
  logic        pending;
  logic [63:0] count_low, count_high;
  logic [RoundW-1:0] round;
  logic        half;
  logic [3:0]  sig_row;
  logic [6:0]  eff_d, eff_k;
  logic [6:0]  reg_digest_next, reg_key_next;
  logic [6:0]  eff_dn, eff_kn;
  logic [63:0] h0_init;
  logic [63:0] masked;
  logic [3:0]  bc;
  logic [63:0] vn [16];
  logic [63:0] held_word;
  logic [3:0]  held_bc;
  logic        held_valid;
  logic [63:0] abs_word;
  logic [3:0]  abs_bc;

  assign reg_digest_next = (cfg_we && !cfg_sel) ? cfg_data : reg_digest;
  assign reg_key_next    = (cfg_we && cfg_sel) ? cfg_data : reg_key;

  assign eff_d = (reg_digest == 7'd0) ? 7'd1 : ((reg_digest > 7'd64) ? 7'd64 : reg_digest);
  assign eff_k = (reg_key > 7'd64) ? 7'd64 : reg_key;
  // Restart on a register write must see the value being written.
  assign eff_dn = (reg_digest_next == 7'd0) ? 7'd1 :
                  ((reg_digest_next > 7'd64) ? 7'd64 : reg_digest_next);
  assign eff_kn = (reg_key_next > 7'd64) ? 7'd64 : reg_key_next;
  assign h0_init = b2b_pkg::Iv[0] ^ 64'h01010000 ^ {49'd0, eff_kn, 8'd0} ^ {57'd0, eff_dn};
  assign bc = (in_count > 4'd8) ? 4'd8 : in_count;
  assign masked = (bc[3]) ? in_word : (in_word & ~({64{1'b1}} << {bc[2:0], 3'b000}));

  // A word taken behind a block compression is absorbed from the hold register.
  assign abs_word = held_valid ? held_word : masked;
  assign abs_bc   = held_valid ? held_bc : bc;

  assign stat.word_pos   = word_pos;
  assign stat.pending    = pending;
  assign stat.run_empty  = (word_pos == 5'd0) && !pending && count_low == 64'd0
                           && count_high == 64'd0;
  assign stat.digest_len = eff_d;

  // Sigma row for the current round; round index stays below 10 for Rounds<=10,
  // otherwise wrap.
  always_comb begin
    if (32'(round) >= 32'd10) sig_row = 4'(32'(round) - 32'd10);
    else sig_row = 4'(round);
  end

  // One half round: four independent G functions, columns or diagonals.
  always_comb begin
    logic [3:0] ia, ib, ic, id;
    logic [63:0] a, b, c, d, x, y;
    for (int i = 0; i < 16; i++) vn[i] = v[i];
    for (int g = 0; g < 4; g++) begin
      ia = 4'(g);
      ib = half ? 4'(4 + ((g + 1) % 4)) : 4'(4 + g);
      ic = half ? 4'(8 + ((g + 2) % 4)) : 4'(8 + g);
      id = half ? 4'(12 + ((g + 3) % 4)) : 4'(12 + g);
      x = blk[b2b_pkg::Sigma[sig_row][{half, 2'(g), 1'b0}]];
      y = blk[b2b_pkg::Sigma[sig_row][{half, 2'(g), 1'b1}]];
      a = v[ia]; b = v[ib]; c = v[ic]; d = v[id];
      a = a + b + x;
      d = b2b_pkg::ror64(d ^ a, 32);
      c = c + d;
      b = b2b_pkg::ror64(b ^ c, 24);
      a = a + b + y;
      d = b2b_pkg::ror64(d ^ a, 16);
      c = c + d;
      b = b2b_pkg::ror64(b ^ c, 63);
      vn[ia] = a; vn[ib] = b; vn[ic] = c; vn[id] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_digest <= 7'd64;
      reg_key    <= 7'd0;
    end else begin
      reg_digest <= reg_digest_next;
      reg_key    <= reg_key_next;
    end
  end

  // Capture the word accepted alongside a non-final compression start.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd.comp_start && !cmd.comp_final) begin
      held_valid <= 1'b1;
      held_word  <= masked;
      held_bc    <= bc;
    end else if (cmd.absorb) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      word_pos   <= 5'd0;
      pending    <= 1'b0;
      count_low  <= 64'd0;
      count_high <= 64'd0;
    end else begin
      if (cmd.comp_done && !cmd.comp_final) begin
        word_pos <= 5'd0;
        pending  <= 1'b0;
      end
      if (cmd.absorb) begin
        blk[word_pos[3:0]] <= abs_word;
        word_pos <= word_pos + 5'd1;
        if (word_pos == 5'd15) pending <= 1'b1;
        {count_high, count_low} <= {count_high, count_low} + {124'd0, abs_bc};
      end
      if (cmd.pad_clear) begin
        blk[word_pos[3:0]] <= 64'd0;
        word_pos <= word_pos + 5'd1;
      end
    end
  end

  // Chain value: reload after reset, config write on an empty run, or run end.
  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 1; i < 8; i++) chain[i] <= b2b_pkg::Iv[i];
      chain[0] <= b2b_pkg::Iv[0] ^ 64'h01010000 ^ {57'd0, 7'd64};
      if (!rst) chain[0] <= h0_init;
    end else if (cmd.comp_done) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] ^ v[i] ^ v[i+8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int i = 0; i < 8; i++) begin
        v[i]   <= chain[i];
        v[i+8] <= b2b_pkg::Iv[i];
      end
      v[12] <= b2b_pkg::Iv[4] ^ count_low;
      v[13] <= b2b_pkg::Iv[5] ^ count_high;
      v[14] <= cmd.comp_final ? ~b2b_pkg::Iv[6] : b2b_pkg::Iv[6];
      round <= '0;
      half  <= 1'b0;
    end else if (cmd.round_step) begin
      for (int i = 0; i < 16; i++) v[i] <= vn[i];
      half <= ~half;
      if (half) round <= round + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    logic [6:0] rem;
    rem = eff_d - {1'b0, cmd.out_idx, 3'b000};
    if (cmd.out_load) begin
      if (rem < 7'd8)
        out_word <= chain[cmd.out_idx] & ~({64{1'b1}} << {rem[2:0], 3'b000});
      else
        out_word <= chain[cmd.out_idx];
    end
  end
endmodule
`default_nettype wire

// File: hdl/b2b_ctrl.sv
// Controller: sequences absorb, compression, padding and digest output.
`default_nettype none
module b2b_ctrl #(
  parameter int Rounds = b2b_pkg::DefaultRounds
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [3:0]        in_count,
  input  wire logic              in_last,
  input  wire logic              cfg_we,
  input  wire b2b_pkg::b2b_stat_t stat,
  output b2b_pkg::b2b_cmd_t      cmd,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_final
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRound = 3'd1;
  localparam logic [2:0] StFold  = 3'd2;
  localparam logic [2:0] StPad   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;
  localparam logic [2:0] StShow  = 3'd5;
  localparam int StepW = $clog2(2 * Rounds + 1);

  logic [2:0] state, state_next;
  logic [StepW-1:0] steps, steps_next;
  logic final_c, final_c_next;   // current compression is the final one
  logic hold_word, hold_word_next; // word waits behind a non-final compression
  logic hold_last, hold_last_next;
  logic [3:0] hold_cnt, hold_cnt_next;
  logic [2:0] oidx, oidx_next;
  logic [3:0] nout;
  logic [3:0] bc;
  logic acc;

  assign nout = 4'((stat.digest_len + 7'd7) >> 3);
  assign bc = (in_count > 4'd8) ? 4'd8 : in_count;
  assign in_ready = (state == StIdle) && !hold_word;
  assign acc = in_valid && in_ready;
  assign out_valid = (state == StShow);
  assign out_final = ({1'b0, oidx} == nout - 4'd1);

  always_comb begin
    state_next = state; steps_next = steps; final_c_next = final_c;
    hold_word_next = hold_word; hold_last_next = hold_last; hold_cnt_next = hold_cnt;
    oidx_next = oidx;
    cmd = '0;
    cmd.out_idx = oidx;
    cmd.comp_final = final_c;
    case (state)
      StIdle: begin
        if (cfg_we && stat.run_empty) cmd.restart = 1'b1;
        if (hold_word) begin
          // Resume the word that triggered the block compression.
          hold_word_next = 1'b0;
          if (hold_cnt != 4'd0) cmd.absorb = 1'b1;
          if (hold_last) state_next = StPad;
        end else if (acc && !(bc == 4'd0 && !in_last)) begin
          if (bc != 4'd0 && stat.pending) begin
            hold_word_next = 1'b1; hold_last_next = in_last; hold_cnt_next = bc;
            final_c_next = 1'b0;
            cmd.comp_start = 1'b1; cmd.comp_final = 1'b0;
            steps_next = '0; state_next = StRound;
          end else begin
            if (bc != 4'd0) cmd.absorb = 1'b1;
            if (in_last) state_next = StPad;
          end
        end
      end
      StPad: begin
        if (stat.word_pos < 5'd16 && !stat.pending) cmd.pad_clear = 1'b1;
        else begin
          final_c_next = 1'b1;
          cmd.comp_start = 1'b1; cmd.comp_final = 1'b1;
          steps_next = '0; state_next = StRound;
        end
      end
      StRound: begin
        cmd.round_step = 1'b1;
        steps_next = steps + 1'b1;
        if (32'(steps) == 2 * Rounds - 1) state_next = StFold;
      end
      StFold: begin
        cmd.comp_done = 1'b1;
        oidx_next = 3'd0;
        state_next = final_c ? StOut : StIdle;
      end
      StOut: begin
        cmd.out_load = 1'b1;
        state_next = StShow;
      end
      StShow: begin
        if (out_ready) begin
          if (out_final) begin
            cmd.restart = 1'b1; state_next = StIdle;
          end else begin
            oidx_next = oidx + 3'd1; state_next = StOut;
          end
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle; hold_word <= 1'b0; steps <= '0; final_c <= 1'b0;
      hold_last <= 1'b0; hold_cnt <= 4'd0; oidx <= 3'd0;
    end else begin
      state <= state_next; steps <= steps_next; final_c <= final_c_next;
      hold_word <= hold_word_next; hold_last <= hold_last_next;
      hold_cnt <= hold_cnt_next; oidx <= oidx_next;
    end
  end

`ifndef SYNTH
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !in_ready) else $error("input taken while busy");
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == StFold) |-> $past(state) == StRound) else $error("fold without rounds");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("digest word dropped");
`endif
endmodule
`default_nettype wire

// File: hdl/blake2b_reduced_round_hash_core.sv
// Top level: reduced-round BLAKE2b streaming hash core with APB registers.
//
// Streaming BLAKE2b hash with a configurable round count (default 6). Feed
// little-endian 64-bit words with a byte count and a last mark; one word is
// taken per accept when no compression runs. A full 16-word block is
// compressed only when the next data word arrives: a load, one half round
// per cycle on a single four-lane G unit, then a fold. The last word pads the
// open block one slot per cycle, compresses it as final, then emits
// ceil(digest_bytes/8) digest words (digest_bytes clamped to 1..64), each
// loaded and shown until taken. Registers: 0x0 digest_bytes, 0x4 key_bytes;
// write only while idle. A write with no data taken restarts the run with
// the new parameters. In keyed mode stream the zero-padded key block first.
`default_nettype none
module blake2b_reduced_round_hash_core #(
  parameter int ROUNDS = b2b_pkg::DefaultRounds
) (
  input  wire logic        clk,
  input  wire logic        rst,
  b2b_in_if.sink           in_ch,
  b2b_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [b2b_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  b2b_pkg::b2b_cmd_t  cmd;
  b2b_pkg::b2b_stat_t stat;
  logic [6:0] reg_digest, reg_key;
  logic cfg_we, cfg_hit;

  assign pready = 1'b1;
  // Write the register only at the access phase; unknown addresses drop.
  assign cfg_hit = (paddr == b2b_pkg::RegDigestBytes) || (paddr == b2b_pkg::RegKeyBytes);
  assign cfg_we  = psel && penable && pwrite && cfg_hit;
  always_comb begin
    case (paddr)
      b2b_pkg::RegDigestBytes: prdata = {25'd0, reg_digest};
      b2b_pkg::RegKeyBytes:    prdata = {25'd0, reg_key};
      default:                 prdata = 32'd0;
    endcase
  end

  b2b_datapath #(.Rounds(ROUNDS)) u_dp (
    .clk, .rst, .cmd,
    .in_word(in_ch.message_word), .in_count(in_ch.byte_count),
    .cfg_we, .cfg_sel(paddr == b2b_pkg::RegKeyBytes), .cfg_data(pwdata[6:0]),
    .stat, .reg_digest, .reg_key, .out_word(out_ch.digest_word)
  );

  b2b_ctrl #(.Rounds(ROUNDS)) u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_count(in_ch.byte_count), .in_last(in_ch.last_word),
    .cfg_we, .stat, .cmd,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_final(out_ch.final_digest)
  );
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Testbench for the reduced-round BLAKE2b streaming hash core.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } msg_req_t;

  typedef struct packed {
    logic [63:0] word;
    logic        fin;
  } digest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [b2b_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  b2b_in_if  in_ch ();
  b2b_out_if out_ch ();

  blake2b_reduced_round_hash_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  msg_req_t requests[$];   // requests waiting to be offered
  digest_t  digests[$];    // digest words still owed by the core
  int errors = 0;
  int rand_reqs = 0;
  bit no_gaps = 1'b0;      // burst mode: sender offers back to back
  bit hold = 1'b0;         // long receiver hold-off
  bit start_hold = 1'b0;

  // Predictor state: chaining value, block buffer, fill point, byte total.
  logic [63:0]  chain [8];
  logic [63:0]  blk [16];
  int           fill;
  logic [127:0] total;
  bit           full_pend;
  logic [6:0]   cfg_digest = 7'd64;
  logic [6:0]   cfg_key = 7'd0;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic int digest_len();
    if (cfg_digest == 0) return 1;
    return cfg_digest > 64 ? 64 : int'(cfg_digest);
  endfunction

  function automatic void new_run();
    logic [63:0] kl;
    kl = cfg_key > 64 ? 64'd64 : 64'(cfg_key);
    for (int i = 0; i < 8; i++) chain[i] = b2b_pkg::Iv[i];
    chain[0] ^= 64'h01010000 ^ (kl << 8) ^ 64'(digest_len());
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill = 0;
    total = '0;
    full_pend = 1'b0;
  endfunction

  function automatic void compress_block(input bit fin);
    logic [63:0] v [16];
    int a, b, c, d, g2;
    for (int i = 0; i < 8; i++) begin
      v[i] = chain[i];
      v[i+8] = b2b_pkg::Iv[i];
    end
    v[12] ^= total[63:0];
    v[13] ^= total[127:64];
    if (fin) v[14] = ~v[14];
    for (int r = 0; r < b2b_pkg::DefaultRounds; r++) begin
      for (int g = 0; g < 8; g++) begin
        // columns first, then diagonals
        if (g < 4) begin
          a = g; b = 4 + g; c = 8 + g; d = 12 + g;
        end else begin
          g2 = g - 4;
          a = g2; b = 4 + (g2 + 1) % 4; c = 8 + (g2 + 2) % 4; d = 12 + (g2 + 3) % 4;
        end
        v[a] = v[a] + v[b] + blk[b2b_pkg::Sigma[r % 10][2*g]];
        v[d] = rotr(v[d] ^ v[a], 32);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 24);
        v[a] = v[a] + v[b] + blk[b2b_pkg::Sigma[r % 10][2*g+1]];
        v[d] = rotr(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 63);
      end
    end
    for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i+8];
  endfunction

  // Absorb one accepted request and queue the digest words it produces.
  function automatic void absorb_request(input msg_req_t q);
    logic [63:0] w, dw;
    int nb, dl, n, rem;
    digest_t e;
    w = q.word;
    nb = q.nbytes > 8 ? 8 : int'(q.nbytes);
    if (!q.last && nb == 0) return;
    if (nb > 0) begin
      if (full_pend || fill >= 16) begin
        compress_block(1'b0);
        fill = 0;
        full_pend = 1'b0;
      end
      if (nb < 8) w &= (64'd1 << (8 * nb)) - 1;
      blk[fill] = w;
      fill++;
      total += 128'(nb);
      if (fill >= 16) full_pend = 1'b1;
    end
    if (!q.last) return;
    for (int i = fill; i < 16; i++) blk[i] = '0;
    compress_block(1'b1);
    dl = digest_len();
    n = (dl + 7) / 8;
    for (int i = 0; i < n; i++) begin
      dw = chain[i];
      rem = dl - 8 * i;
      if (rem < 8) dw &= (64'd1 << (8 * rem)) - 1;
      e.word = dw;
      e.fin = (i == n - 1);
      digests.push_back(e);
    end
    new_run();
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic int draw_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Sender: offer queued requests, predict on each accepted one.
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.message_word <= '0;
      in_ch.byte_count <= '0;
      in_ch.last_word <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid && in_ch.ready) absorb_request(requests.pop_front());
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (requests.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.message_word <= requests[0].word;
        in_ch.byte_count <= requests[0].nbytes;
        in_ch.last_word <= requests[0].last;
        in_gap <= draw_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, check each digest word against the oldest owed.
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (digests.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %h", out_ch.digest_word));
        end else begin
          if (out_ch.digest_word !== digests[0].word)
            report_mismatch($sformatf("digest_word got %h want %h",
                                      out_ch.digest_word, digests[0].word));
          if (out_ch.final_digest !== digests[0].fin)
            report_mismatch($sformatf("final_digest got %b want %b",
                                      out_ch.final_digest, digests[0].fin));
          void'(digests.pop_front());
        end
      end
      if (out_gap > 0) out_gap <= out_gap - 1;
      else out_gap <= draw_gap();
      out_ch.ready <= !hold && out_gap == 0;
    end
  end

  // Long hold-off on the receiver so the core backs up and stalls its input.
  initial begin
    wait (start_hold);
    @(posedge clk);
    hold <= 1'b1;
    repeat (400) @(posedge clk);
    hold <= 1'b0;
  end

  task automatic push_req(input logic [63:0] w, input logic [3:0] nb, input bit last);
    msg_req_t q;
    q.word = w;
    q.nbytes = nb;
    q.last = last;
    requests.push_back(q);
  endtask

  // Queue n full words of random content, then a last word of last_nb bytes.
  task automatic push_msg(input int n, input logic [3:0] last_nb);
    for (int i = 0; i < n; i++) push_req({$urandom, $urandom}, 4'd8, 1'b0);
    push_req({$urandom, $urandom}, last_nb, 1'b1);
  endtask

  // Wait until every request is in and every digest word out, plus slack.
  task automatic drain();
    while (requests.size() > 0 || digests.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle; the register updates at the access edge.
  task automatic reg_write(input logic [b2b_pkg::AddrW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == b2b_pkg::RegDigestBytes) cfg_digest = data[6:0];
    else cfg_key = data[6:0];
    new_run();  // idle write with no data taken restarts the run
  endtask

  task automatic set_params(input logic [31:0] dig, input logic [31:0] key);
    drain();
    reg_write(b2b_pkg::RegDigestBytes, dig);
    reg_write(b2b_pkg::RegKeyBytes, key);
  endtask

  initial begin
    new_run();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, all-ones word, saturating byte count.
    push_req(64'h0, 4'd0, 1'b1);
    push_req('1, 4'd8, 1'b1);
    push_req('1, 4'd15, 1'b1);
    // Short word mid-message, then an ignored empty word, then a short last.
    push_req('1, 4'd3, 1'b0);
    push_req(64'h0123456789abcdef, 4'd0, 1'b0);
    push_req('1, 4'd5, 1'b1);
    // Exactly one block, closed by a full last word, then by an empty last word: pending block is final.
    push_msg(15, 4'd8);
    for (int i = 0; i < 16; i++) push_req({$urandom, $urandom}, 4'd8, 1'b0);
    push_req(64'h0, 4'd0, 1'b1);
    // One block and one word: the full block compresses as non-final.
    push_msg(16, 4'd1);
    set_params(32'd1, 32'd0);
    push_msg(0, 4'd8);
    // Zero digest length (with junk above the field) and oversized key.
    set_params(32'hffff_ff80, 32'd127);
    push_msg(1, 4'd7);
    set_params(32'd100, 32'd64);
    // Keyed run: zero-padded key block, then data.
    for (int i = 0; i < 8; i++) push_req('1, 4'd8, 1'b0);
    for (int i = 0; i < 8; i++) push_req(64'h0, 4'd8, 1'b0);
    push_msg(2, 4'd4);
    set_params(32'd20, 32'd0);
    push_msg(3, 4'd8);

    // Random: mostly well-formed messages, some noise words in between.
    while (rand_reqs < 20) begin
      if ($urandom_range(0, 3) == 0)
        set_params($urandom_range(0, 127) | ($urandom << 7), $urandom_range(0, 127));
      no_gaps = $urandom_range(0, 3) == 0;
      if (rand_reqs > 5 && !start_hold) start_hold = 1'b1;
      begin
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 20) : $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 7) == 0)
            push_req({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
          else
            push_req({$urandom, $urandom}, 4'd8, 1'b0);
        end
        push_req({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
        rand_reqs += n + 1;
      end
    end
    start_hold = 1'b1;

    drain();
    if (errors == 0) begin
      $display("PASS blake2b_reduced_round_hash_core");
    end else begin
      $display("FAIL blake2b_reduced_round_hash_core");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("FAIL blake2b_reduced_round_hash_core");
    $finish;
  end

endmodule
`default_nettype wire
